>>> sv/brf_pkg.sv
// Package for the byte ring FIFO: sizes, operation codes, sequencer states
// and the ring size helper. No dependencies.
`default_nettype none

package brf_pkg;

  localparam int unsigned DEPTH_LOG2 = 10;
  localparam int unsigned MAX_BURST  = 64;
  localparam int unsigned ADDR_W     = DEPTH_LOG2;
  localparam int unsigned PTR_W      = DEPTH_LOG2 + 1;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned OFF_W      = 6;
  localparam int unsigned LOG_W      = 4;
  localparam int unsigned PADDR_W    = 3;

  localparam logic [LOG_W-1:0] LOG2_RESET = LOG_W'(DEPTH_LOG2);
  localparam logic [LOG_W-1:0] LOG2_MIN   = LOG_W'(1);
  localparam logic [0:0]       REG_DEPTH_LOG2 = 1'b0;

  typedef enum logic [2:0] {
    FN_WRITE      = 3'd0,
    FN_READ       = 3'd1,
    FN_PEEK       = 3'd2,
    FN_BURST_READ = 3'd3,
    FN_BURST_PEEK = 3'd4,
    FN_CLEAR      = 3'd5
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_e;

  // Clamp the configured log2 size to the supported range.
  function automatic logic [LOG_W-1:0] eff_log2(input logic [LOG_W-1:0] v);
    logic [LOG_W-1:0] r;
    r = v;
    if (v < LOG2_MIN) r = LOG2_MIN;
    if (v > LOG2_RESET) r = LOG2_RESET;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/byte_ring_fifo.sv
// Byte FIFO on a power-of-two ring: pointers, sequencer and APB register.
// Depends on brf_pkg and brf_ram (storage).
//
// Results are registered: a byte request's result, or a burst's first byte,
// appears in the cycle after the request is accepted. Byte write, read, peek
// and clear never set busy and run back to back. A burst of more than one byte
// holds busy: one storage RAM read per cycle, one result per cycle. The receiver cannot stall.
// Reset clears both pointers and sets depth_log2 to 10; storage is not cleared.
`default_nettype none

module byte_ring_fifo
  import brf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         func_i,
  input  wire logic [7:0]         data_in_i,
  input  wire logic [LEN_W-1:0]   burst_length_i,
  output logic                    valid_o,
  output logic                    ok_o,
  output logic [7:0]              data_out_o,
  output logic [PTR_W-1:0]        level_o,
  output logic                    last_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic              brd_q, brd_d;
  logic [LOG_W-1:0]  log2_q;
  logic              valid_q, valid_d, ok_q, ok_d, last_q, last_d;
  logic              use_ram_q, use_ram_d;
  logic [PTR_W-1:0]  level_q, level_d;

  logic              cfg_we, size_chg;
  logic [LOG_W-1:0]  new_log2;
  logic [PTR_W-1:0]  size, lvl;
  logic [ADDR_W-1:0] mask;
  logic [LEN_W-1:0]  blen_c, n_c;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && (paddr[2] == REG_DEPTH_LOG2);
  assign new_log2 = pwdata[LOG_W-1:0];
  assign size_chg = eff_log2(new_log2) != eff_log2(log2_q);
  assign prdata   = (paddr[2] == REG_DEPTH_LOG2) ? {{(32-LOG_W){1'b0}}, log2_q} : 32'd0;

  assign size   = PTR_W'(1) << eff_log2(log2_q);
  assign mask   = ADDR_W'(size - PTR_W'(1));
  assign lvl    = wp_q - rp_q;
  assign blen_c = (burst_length_i > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : burst_length_i;
  assign n_c    = ({{(PTR_W-LEN_W){1'b0}}, blen_c} > lvl) ? lvl[LEN_W-1:0] : blen_c;

  assign busy       = (state_q == ST_BURST);
  assign valid_o    = valid_q;
  assign ok_o       = ok_q;
  assign last_o     = last_q;
  assign level_o    = level_q;
  assign data_out_o = (valid_q && use_ram_q) ? ram_rdata : 8'd0;
  assign ram_waddr  = ADDR_W'(wp_q) & mask;

  brf_ram #(
    .WIDTH(8),
    .DEPTH(1 << DEPTH_LOG2)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(data_in_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    rem_d     = rem_q;
    off_d     = off_q;
    brd_d     = brd_q;
    valid_d   = 1'b0;
    ok_d      = 1'b0;
    last_d    = 1'b1;
    use_ram_d = 1'b0;
    level_d   = level_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(rp_q) & mask;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          valid_d = 1'b1;
          level_d = lvl;
          case (func_i) inside
            FN_WRITE: begin
              if (lvl < size) begin
                ram_we  = 1'b1;
                wp_d    = wp_q + PTR_W'(1);
                ok_d    = 1'b1;
                level_d = lvl + PTR_W'(1);
              end
            end
            FN_READ, FN_PEEK: begin
              if (lvl != '0) begin
                ram_re    = 1'b1;
                use_ram_d = 1'b1;
                ok_d      = 1'b1;
                if (func_i == FN_READ) begin
                  rp_d    = rp_q + PTR_W'(1);
                  level_d = lvl - PTR_W'(1);
                end
              end
            end
            FN_BURST_READ, FN_BURST_PEEK: begin
              if (n_c != '0) begin
                ram_re    = 1'b1;
                use_ram_d = 1'b1;
                ok_d      = 1'b1;
                last_d    = (n_c == LEN_W'(1));
                brd_d     = (func_i == FN_BURST_READ);
                if (func_i == FN_BURST_READ) begin
                  rp_d    = rp_q + PTR_W'(1);
                  level_d = lvl - PTR_W'(1);
                end
                if (n_c != LEN_W'(1)) begin
                  state_d = ST_BURST;
                  rem_d   = CNT_W'(n_c - LEN_W'(1));
                  off_d   = OFF_W'(1);
                end
              end
            end
            FN_CLEAR: begin
              wp_d    = '0;
              rp_d    = '0;
              level_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BURST: begin
        valid_d   = 1'b1;
        ok_d      = 1'b1;
        use_ram_d = 1'b1;
        ram_re    = 1'b1;
        last_d    = (rem_q == CNT_W'(1));
        rem_d     = rem_q - CNT_W'(1);
        off_d     = off_q + OFF_W'(1);
        if (brd_q) begin
          rp_d    = rp_q + PTR_W'(1);
          level_d = lvl - PTR_W'(1);
        end else begin
          ram_raddr = ADDR_W'(rp_q + {{(PTR_W-OFF_W){1'b0}}, off_q}) & mask;
          level_d   = lvl;
        end
        if (rem_q == CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A size change empties the ring.
    if (cfg_we && size_chg) begin
      wp_d = '0;
      rp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      log2_q  <= LOG2_RESET;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      valid_q <= valid_d;
      if (cfg_we) begin
        log2_q <= new_log2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    off_q     <= off_d;
    brd_q     <= brd_d;
    ok_q      <= ok_d;
    last_q    <= last_d;
    use_ram_q <= use_ram_d;
    level_q   <= level_d;
  end

endmodule

`default_nettype wire

>>> sv/brf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
